@@ src/ffba_pkg.sv @@
// shared types and constants of the first-fit block allocator
// no dependencies; used by the controller, the datapath and the top level
package ffba_pkg;

    // extra bytes a remainder must carry beyond one header before a split
    localparam int SPLIT_SLACK = 16;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_ZERO  = 3'd1,
        ST_NOFIT = 3'd2,
        ST_FULL  = 3'd3,
        ST_SMALL = 3'd4
    } ffba_status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_HIT,
        S_UPDATE,
        S_RESULT
    } ffba_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic         load_req;
        logic         add_write;
        logic         alloc_start;
        logic         walk_step;
        logic         hit_eval;
        logic         split_write;
        logic         update_write;
        logic         set_status;
        logic         set_addr;
        ffba_status_t status_code;
    } ffba_cmd_t;

    // status flags from the datapath to the controller
    typedef struct packed {
        logic is_alloc;
        logic size_zero;
        logic size_small;
        logic table_full;
        logic chain_empty;
        logic hit;
        logic walk_end;
        logic split_ok;
    } ffba_flags_t;

endpackage

@@ src/ffba_ram.sv @@
// generic single-port-write, single-port-read memory with registered read
// no dependencies
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/ffba_ctrl.sv @@
// controller state machine of the first-fit block allocator
// depends on ffba_pkg (state, command and flag types)
module ffba_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output logic                 done,
    input  ffba_pkg::ffba_flags_t flags,
    output ffba_pkg::ffba_cmd_t   cmd
);

    ffba_pkg::ffba_state_t state_reg;
    ffba_pkg::ffba_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.status_code = ffba_pkg::ST_OK;
        busy            = 1'b1;
        done            = 1'b0;
        unique case (state_reg)
            ffba_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ffba_pkg::S_DECODE;
                end
            end
            ffba_pkg::S_DECODE:
            begin
                if (!flags.is_alloc)
                begin
                    cmd.set_status = 1'b1;
                    state_next     = ffba_pkg::S_RESULT;
                    priority if (flags.size_zero)
                        cmd.status_code = ffba_pkg::ST_ZERO;
                    else if (flags.size_small)
                        cmd.status_code = ffba_pkg::ST_SMALL;
                    else if (flags.table_full)
                        cmd.status_code = ffba_pkg::ST_FULL;
                    else
                    begin
                        cmd.status_code = ffba_pkg::ST_OK;
                        cmd.add_write   = 1'b1;
                    end
                end
                else
                begin
                    priority if (flags.size_zero)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ffba_pkg::ST_ZERO;
                        state_next      = ffba_pkg::S_RESULT;
                    end
                    else if (flags.chain_empty)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ffba_pkg::ST_NOFIT;
                        state_next      = ffba_pkg::S_RESULT;
                    end
                    else
                    begin
                        cmd.alloc_start = 1'b1;
                        state_next      = ffba_pkg::S_WALK;
                    end
                end
            end
            ffba_pkg::S_WALK:
            begin
                priority if (flags.hit)
                    state_next = ffba_pkg::S_HIT;
                else if (flags.walk_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ffba_pkg::ST_NOFIT;
                    state_next      = ffba_pkg::S_RESULT;
                end
                else
                    cmd.walk_step = 1'b1;
            end
            ffba_pkg::S_HIT:
            begin
                cmd.hit_eval    = 1'b1;
                cmd.split_write = flags.split_ok;
                state_next      = ffba_pkg::S_UPDATE;
            end
            ffba_pkg::S_UPDATE:
            begin
                cmd.update_write = 1'b1;
                cmd.set_status   = 1'b1;
                cmd.set_addr     = 1'b1;
                cmd.status_code  = ffba_pkg::ST_OK;
                state_next       = ffba_pkg::S_RESULT;
            end
            ffba_pkg::S_RESULT:
            begin
                done       = 1'b1;
                state_next = ffba_pkg::S_IDLE;
            end
            default:
            begin
                state_next = ffba_pkg::S_IDLE;
            end
        endcase
    end

    // an accepted transaction keeps the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not make the unit busy");

    // the result strobe ends the transaction
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("unit still busy after result strobe");

    // a chain walk step is only issued while walking
    a_walk_state: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk_step |-> (state_reg == ffba_pkg::S_WALK && !flags.hit))
        else $error("walk step outside the walk");

endmodule

@@ src/ffba_dpath.sv @@
// datapath of the first-fit block allocator: request registers, chain head,
// slot count, walk pointer and the descriptor table in ffba_ram
// depends on ffba_pkg and ffba_ram
module ffba_dpath #(
    parameter int MAX_NODES    = 16,
    parameter int HEADER_BYTES = 32,
    parameter int NODE_BYTES   = 32,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_type,
    input  logic [31:0]           region_addr,
    input  logic [31:0]           req_size,
    input  ffba_pkg::ffba_cmd_t   cmd,
    output ffba_pkg::ffba_flags_t flags,
    output logic [2:0]            status,
    output logic [31:0]           block_addr
);

    localparam int IW = $clog2(MAX_NODES + 1);
    localparam int XW = $clog2(MAX_NODES);
    localparam int CW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
    localparam int CX = CW + 1;
    localparam int DW = 3 * ADDR_WIDTH + 1 + IW;

    localparam logic [IW-1:0] END_IX   = IW'(MAX_NODES);
    localparam logic [IW-1:0] LAST_STEP = IW'(MAX_NODES - 1);
    localparam logic [CX-1:0] HDR_X    = CX'(HEADER_BYTES);
    localparam logic [CX-1:0] NODE_X   = CX'(NODE_BYTES);
    localparam logic [CX-1:0] SLACK_X  = CX'(HEADER_BYTES + ffba_pkg::SPLIT_SLACK);
    localparam logic [31:0]   MIN_ADD  = 32'(2 * NODE_BYTES);

    // request and control registers
    logic                  req_type_reg;
    logic [31:0]           region_reg;
    logic [31:0]           size_reg;
    logic [IW-1:0]         head_reg;
    logic [IW-1:0]         head_next;
    logic [IW-1:0]         slots_reg;
    logic [IW-1:0]         slots_next;
    logic [IW-1:0]         cur_reg;
    logic [IW-1:0]         steps_reg;
    logic                  split_reg;
    logic [2:0]            status_reg;
    logic [31:0]           addr_reg;

    // descriptor table ports
    logic                  ram_we;
    logic [XW-1:0]         ram_waddr;
    logic [DW-1:0]         ram_wdata;
    logic                  ram_re;
    logic [XW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_rdata;

    // fields of the descriptor just read
    logic [ADDR_WIDTH-1:0] rd_base;
    logic [ADDR_WIDTH-1:0] rd_total;
    logic [ADDR_WIDTH-1:0] rd_usable;
    logic                  rd_free;
    logic [IW-1:0]         rd_next;

    // arithmetic
    logic [CX-1:0]         size_x;
    logic [CX-1:0]         total_x;
    logic [CX-1:0]         usable_x;
    logic [CX-1:0]         need_x;
    logic [CX-1:0]         diff_x;
    logic [ADDR_WIDTH-1:0] data_a;
    logic [ADDR_WIDTH-1:0] new_base;
    logic [ADDR_WIDTH-1:0] new_total;
    logic [ADDR_WIDTH-1:0] new_usable;
    logic [ADDR_WIDTH-1:0] add_usable;
    logic [DW-1:0]         add_word;
    logic [DW-1:0]         split_word;
    logic [DW-1:0]         upd_word;

    ffba_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // descriptor word: {free, next, usable, total, base}
    assign rd_base   = ram_rdata[ADDR_WIDTH-1:0];
    assign rd_total  = ram_rdata[2*ADDR_WIDTH-1:ADDR_WIDTH];
    assign rd_usable = ram_rdata[3*ADDR_WIDTH-1:2*ADDR_WIDTH];
    assign rd_next   = ram_rdata[3*ADDR_WIDTH+IW-1:3*ADDR_WIDTH];
    assign rd_free   = ram_rdata[DW-1];

    // size and address arithmetic, wrapping at the address width; the new usable size floors at zero
    assign size_x     = CX'(size_reg);
    assign total_x    = CX'(rd_total);
    assign usable_x   = CX'(rd_usable);
    assign need_x     = size_x + HDR_X;
    assign diff_x     = total_x - size_x;
    assign data_a     = ADDR_WIDTH'(CX'(rd_base) + HDR_X);
    assign new_base   = ADDR_WIDTH'(CX'(data_a) + size_x);
    assign new_total  = ADDR_WIDTH'(total_x - need_x);
    assign new_usable = (usable_x >= need_x) ? ADDR_WIDTH'(usable_x - need_x) : '0;
    assign add_usable = ADDR_WIDTH'(size_x - NODE_X);

    assign add_word   = {1'b1, head_reg, add_usable, ADDR_WIDTH'(size_x),
                         ADDR_WIDTH'(CX'(region_reg))};
    assign split_word = {1'b1, rd_next, new_usable, new_total, new_base};
    assign upd_word   = split_reg
                      ? {1'b0, IW'(slots_reg - IW'(1)), ADDR_WIDTH'(size_x),
                         ADDR_WIDTH'(need_x), rd_base}
                      : {1'b0, rd_next, rd_usable, rd_total, rd_base};

    // table write and read port selection
    always_comb
    begin
        ram_we    = cmd.add_write | cmd.split_write | cmd.update_write;
        ram_waddr = cmd.update_write ? cur_reg[XW-1:0] : slots_reg[XW-1:0];
        priority if (cmd.add_write)
            ram_wdata = add_word;
        else if (cmd.split_write)
            ram_wdata = split_word;
        else
            ram_wdata = upd_word;
        ram_re    = cmd.alloc_start | cmd.walk_step;
        ram_raddr = cmd.walk_step ? rd_next[XW-1:0] : head_reg[XW-1:0];
    end

    // flags for the controller
    always_comb
    begin
        flags.is_alloc    = req_type_reg;
        flags.size_zero   = (size_reg == 32'd0);
        flags.size_small  = (size_reg < MIN_ADD);
        flags.table_full  = (slots_reg >= END_IX);
        flags.chain_empty = (head_reg >= END_IX);
        flags.hit         = rd_free && (usable_x >= size_x);
        flags.walk_end    = (steps_reg == LAST_STEP) || (rd_next >= END_IX);
        flags.split_ok    = (total_x >= size_x) && (diff_x >= SLACK_X)
                          && (slots_reg < END_IX);
    end

    // chain head and slot count
    always_comb
    begin
        head_next  = head_reg;
        slots_next = slots_reg;
        if (cmd.add_write)
        begin
            head_next  = slots_reg;
            slots_next = slots_reg + IW'(1);
        end
        else if (cmd.split_write)
        begin
            slots_next = slots_reg + IW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= END_IX;
            slots_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            slots_reg <= slots_next;
        end
    end

    // request, walk and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            region_reg   <= region_addr;
            size_reg     <= req_size;
        end
        if (cmd.alloc_start)
        begin
            cur_reg   <= head_reg;
            steps_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            cur_reg   <= rd_next;
            steps_reg <= steps_reg + IW'(1);
        end
        if (cmd.hit_eval)
        begin
            split_reg <= cmd.split_write;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status_code;
            addr_reg   <= cmd.set_addr ? 32'(CX'(data_a)) : 32'd0;
        end
    end

    assign status     = status_reg;
    assign block_addr = addr_reg;

    // the slot count never passes the table depth
    a_slots_bound: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg <= END_IX)
        else $error("slot count beyond table depth");

    // the chain head moves only when a region is added
    a_head_move: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(head_reg) |-> $past(cmd.add_write))
        else $error("chain head changed without an add");

    // a new descriptor is only written while a slot is free
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.add_write || cmd.split_write) |-> (slots_reg < END_IX))
        else $error("descriptor written into a full table");

endmodule

@@ src/first_fit_block_allocator_unit.sv @@
// first-fit block allocator: add requests push free regions onto a descriptor chain,
// allocate requests walk it one descriptor per cycle and may split the block found
// add and early rejects go from decode straight to the result strobe; an allocate goes
// through decode, walk, hit and update to the strobe, or from the walk to it when no
// descriptor fits after at most MAX_NODES visited; next transaction taken the cycle after
// the strobe, walks use the single table read port; reset empties chain and slot count
module first_fit_block_allocator_unit #(
    parameter int MAX_NODES    = 16,
    parameter int HEADER_BYTES = 32,
    parameter int NODE_BYTES   = 32,
    parameter int ADDR_WIDTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        req_type,
    input  logic [31:0] region_addr,
    input  logic [31:0] req_size,
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] block_addr
);

    ffba_pkg::ffba_cmd_t   cmd;
    ffba_pkg::ffba_flags_t flags;

    // controller
    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .flags (flags),
        .cmd   (cmd)
    );

    // datapath with descriptor table
    ffba_dpath #(
        .MAX_NODES    (MAX_NODES),
        .HEADER_BYTES (HEADER_BYTES),
        .NODE_BYTES   (NODE_BYTES),
        .ADDR_WIDTH   (ADDR_WIDTH)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .region_addr (region_addr),
        .req_size    (req_size),
        .cmd         (cmd),
        .flags       (flags),
        .status      (status),
        .block_addr  (block_addr)
    );

endmodule
